/* hw/rtl/pcfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfd_pkg
// Types and constants shared by the PWM frequency and duty meter.
// ----------------------------------------------------------------------------
package pcfd_pkg;

    localparam int STAMP_W     = 16;
    localparam int WRAP_W      = 16;
    localparam int CLOCK_W     = 28;
    localparam int FREQ_W      = 35;
    localparam int DUTY_W      = 7;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_DATA_W  = 28;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;
    localparam logic [WRAP_W-1:0]  WRAP_RESET  = 16'd65535;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd8000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_PERIOD = 1'b0,
        CFG_CLOCK_HZ    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [STAMP_W-1:0] rising_stamp;
        logic [STAMP_W-1:0] falling_stamp;
    } capture_item_t;

    typedef struct packed {
        logic               measurement_done;
        logic [STAMP_W-1:0] period_ticks;
        logic [STAMP_W-1:0] high_ticks;
        logic [FREQ_W-1:0]  frequency_q8;
        logic [DUTY_W-1:0]  duty_percent;
        logic               duty_clipped;
    } result_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hw/rtl/pcfd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfd_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcfd_div
    import pcfd_pkg::*;
#(
    parameter int NUM_W = 36,
    parameter int DEN_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output div_status_t      status
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg   <= dividend;
                rem_reg   <= '0;
                den_reg   <= divisor;
                count_reg <= CNT_W'(NUM_W);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg   <= {quo_reg[NUM_W-2:0], fits};
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // remainder stays below the divisor while iterating
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < den_reg || den_reg == '0)
        else $error("divider remainder out of range");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != '0)
        else $error("divider count exhausted while busy");

endmodule

/* hw/rtl/pwm_capture_freq_duty_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_capture_freq_duty_meter
// Capture-event PWM meter: period, high time, frequency (Q.8 Hz) and duty.
// ----------------------------------------------------------------------------
// channel   | signals                                   | direction
// capture   | capture_valid, capture_stall, capture     | in (stall out)
// result    | result_valid, result_stall, result        | out (stall in)
// config    | cfg_we, cfg_index, cfg_data               | in, write only
//
// Arming capture: straight to publish. Short period: both differences, then publish.
// Full measurement: both differences, multiply, duty and frequency divisions, publish,
// with the single shared divider running duty then frequency.
// capture_stall is high while an item is in work; one result item per capture.
// A finished result waits in the output register while the next item is taken.
// Reset: disarmed, held values zero, registers at defaults.
// ----------------------------------------------------------------------------
module pwm_capture_freq_duty_meter
    import pcfd_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  capture_valid,
    output logic                  capture_stall,
    input  capture_item_t         capture,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_item_t          result,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CB     = COUNTER_BITS;
    localparam int NUM_W  = (CB + DUTY_W > CLOCK_W + FRAC_BITS) ? CB + DUTY_W
                                                                : CLOCK_W + FRAC_BITS;
    localparam int DIFF_W = (CB > STAMP_W + 1) ? CB : STAMP_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF_PER,
        S_DIFF_HI,
        S_MUL,
        S_DIV_DUTY,
        S_DIV_FREQ,
        S_PUBLISH
    } state_t;

    state_t              state_reg;
    logic [WRAP_W-1:0]   wrap_reg;
    logic [CLOCK_W-1:0]  clock_reg;
    logic [STAMP_W-1:0]  rise_reg;
    logic [STAMP_W-1:0]  fall_reg;
    logic [STAMP_W-1:0]  first_reg;
    logic                armed_reg;
    logic [CB-1:0]       per_reg;
    logic [CB-1:0]       hi_reg;
    logic [NUM_W-1:0]    prod_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic                clip_reg;
    logic [FREQ_W-1:0]   held_freq_reg;
    logic [DUTY_W-1:0]   held_duty_reg;
    logic                held_clip_reg;
    logic                done_flag_reg;
    logic                div_start_reg;
    result_item_t        result_reg;
    logic                result_valid_reg;

    logic [STAMP_W-1:0]  stamp_sel;
    logic [DIFF_W-1:0]   diff_full;
    logic [CB-1:0]       diff_val;
    logic [NUM_W-1:0]    div_dividend;
    logic [NUM_W-1:0]    div_quotient;
    div_status_t         div_stat;
    logic                take_capture;
    logic                out_free;

    assign take_capture = capture_valid && !capture_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    // shared wrap-corrected difference
    assign stamp_sel = (state_reg == S_DIFF_HI) ? fall_reg : rise_reg;
    always_comb
    begin
        if (stamp_sel > first_reg)
            diff_full = DIFF_W'(stamp_sel) - DIFF_W'(first_reg);
        else
            diff_full = DIFF_W'(wrap_reg) - DIFF_W'(first_reg) + DIFF_W'(stamp_sel);
    end
    assign diff_val = diff_full[CB-1:0];

    assign div_dividend = (state_reg == S_DIV_FREQ)
                        ? NUM_W'({clock_reg, {FRAC_BITS{1'b0}}})
                        : prod_reg;

    pcfd_div #(
        .NUM_W (NUM_W),
        .DEN_W (CB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (per_reg),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg  <= WRAP_RESET;
            clock_reg <= CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WRAP_PERIOD: wrap_reg  <= cfg_data[WRAP_W-1:0];
                CFG_CLOCK_HZ:    clock_reg <= cfg_data[CLOCK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rise_reg         <= '0;
            fall_reg         <= '0;
            first_reg        <= '0;
            armed_reg        <= 1'b0;
            per_reg          <= '0;
            hi_reg           <= '0;
            prod_reg         <= '0;
            duty_reg         <= '0;
            clip_reg         <= 1'b0;
            held_freq_reg    <= '0;
            held_duty_reg    <= '0;
            held_clip_reg    <= 1'b0;
            done_flag_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (take_capture)
                    begin
                        rise_reg      <= capture.rising_stamp;
                        fall_reg      <= capture.falling_stamp;
                        done_flag_reg <= 1'b0;
                        if (!armed_reg)
                        begin
                            first_reg <= capture.rising_stamp;
                            armed_reg <= 1'b1;
                            per_reg   <= '0;
                            hi_reg    <= '0;
                            state_reg <= S_PUBLISH;
                        end
                        else
                            state_reg <= S_DIFF_PER;
                    end
                end
                S_DIFF_PER:
                begin
                    per_reg   <= diff_val;
                    state_reg <= S_DIFF_HI;
                end
                S_DIFF_HI:
                begin
                    hi_reg <= diff_val;
                    if (per_reg > CB'(1))
                        state_reg <= S_MUL;
                    else
                        state_reg <= S_PUBLISH;
                end
                S_MUL:
                begin
                    prod_reg      <= NUM_W'(hi_reg) * NUM_W'(DUTY_MAX);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV_DUTY;
                end
                S_DIV_DUTY:
                begin
                    if (div_stat.done)
                    begin
                        if (div_quotient > NUM_W'(DUTY_MAX))
                        begin
                            duty_reg <= DUTY_MAX;
                            clip_reg <= 1'b1;
                        end
                        else
                        begin
                            duty_reg <= div_quotient[DUTY_W-1:0];
                            clip_reg <= 1'b0;
                        end
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV_FREQ;
                    end
                end
                S_DIV_FREQ:
                begin
                    if (div_stat.done)
                    begin
                        held_freq_reg <= div_quotient[FREQ_W-1:0];
                        held_duty_reg <= duty_reg;
                        held_clip_reg <= clip_reg;
                        armed_reg     <= 1'b0;
                        done_flag_reg <= 1'b1;
                        state_reg     <= S_PUBLISH;
                    end
                end
                S_PUBLISH:
                begin
                    if (out_free)
                    begin
                        result_reg.measurement_done <= done_flag_reg;
                        result_reg.period_ticks     <= STAMP_W'(per_reg);
                        result_reg.high_ticks       <= STAMP_W'(hi_reg);
                        result_reg.frequency_q8     <= held_freq_reg;
                        result_reg.duty_percent     <= held_duty_reg;
                        result_reg.duty_clipped     <= held_clip_reg;
                        result_valid_reg            <= 1'b1;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign capture_stall = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    a_done_needs_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUBLISH && done_flag_reg) |-> per_reg > CB'(1))
        else $error("measurement completed with short period");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_duty_reg <= DUTY_MAX)
        else $error("held duty above limit");

    a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        held_clip_reg |-> held_duty_reg == DUTY_MAX)
        else $error("clip flag without saturated duty");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_disarm_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_FREQ && div_stat.done) |=> !armed_reg)
        else $error("still armed after measurement");

endmodule
